>>> hdl/cbm_pkg.sv
package cbm_pkg;

  localparam int PRG_BANKS_MAX = 32;

  localparam logic [1:0] KIND_CPU_READ  = 2'd0;
  localparam logic [1:0] KIND_CPU_WRITE = 2'd1;
  localparam logic [1:0] KIND_PAT_READ  = 2'd2;

  localparam logic [2:0] MAP_FIXED  = 3'd0;
  localparam logic [2:0] MAP_SERIAL = 3'd1;
  localparam logic [2:0] MAP_LOWSW  = 3'd2;
  localparam logic [2:0] MAP_PATSW  = 3'd3;
  localparam logic [2:0] MAP_EIGHT  = 3'd4;

  localparam logic [1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [1:0] CFG_PRG_BANKS   = 2'd1;
  localparam logic [1:0] CFG_CHR_BANKS   = 2'd2;
  localparam logic [1:0] CFG_FIXED_HIGH  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
  } cbm_in_t;

  typedef struct packed {
    logic        rom_hit;
    logic [18:0] prg_offset;
    logic [17:0] chr_offset;
    logic        mirroring;
  } cbm_out_t;

endpackage

>>> hdl/cbm_mod_unit.sv
// Sequential remainder: subtracts shifted copies of the divisor, one bit per cycle.
module cbm_mod_unit import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [8:0]  dividend_i,
  input  logic [8:0]  divisor_i,
  output logic        done_o,
  output logic [8:0]  rem_o
);
  logic [8:0]  rem_q, rem_d;
  logic [17:0] dsh_q, dsh_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = {1'b0, divisor_i, 8'd0};
      cnt_d  = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({9'd0, rem_q} >= dsh_q) begin
        rem_d = rem_q - dsh_q[8:0];
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd8) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

>>> hdl/cartridge_bank_mapper_unit.sv
// Cartridge bank mapper. Each input transaction is a CPU read, a CPU write or
// a pattern-table read; every one produces exactly one result transaction
// carrying rom_hit, the PRG or CHR byte offset and the current mirroring.
// Both channels use valid/stall; the configuration port is a valid/ready
// write channel indexed by register number and is always ready.
// Bank numbers are reduced modulo the configured ROM size by a single shared
// remainder unit that retires one quotient bit per cycle. When a reduction is
// needed the result passes through a setup step, an issue step, nine remainder
// steps and a write-back step. Transactions that need no reduction (misses,
// most writes) go from the setup step straight to the output register.
// The block accepts one transaction at a time and takes the next one only
// in the cycle after its result has left the output register.
// If the receiver stalls, the result is held unchanged in the output
// register and the input side stays stalled.
// Reset selects the fixed mapper with one PRG bank and no CHR ROM and clears
// all bank, shift and mirroring state.
module cartridge_bank_mapper_unit import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cbm_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cbm_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] mkind_q;
  logic [5:0] prgb_q, chrb_q;
  logic [4:0] fixhi_q;

  logic [4:0] shv_q, ctrl_q, chrlo_q, chrhi_q;
  logic [2:0] shc_q, bsel_q;
  logic [3:0] sprg_q;
  logic [1:0] modes_q;
  logic [7:0] bregs_q [8];
  logic [7:0] lowb_q, patb_q;
  logic       mirror_q;

  logic [2:0] st_q;
  cbm_in_t    item_q;
  cbm_out_t   res_q;
  logic [8:0] num_q, div_q;
  logic       wr_reg_q;
  logic [2:0] wr_idx_q;
  logic [3:0] shift_q;   // log2 of page size
  logic [13:0] low_q;

  logic       md_start, md_done;
  logic [8:0] md_rem;

  cbm_mod_unit u_mod (
    .clk_i, .rst_ni,
    .start_i(md_start), .dividend_i(num_q), .divisor_i(div_q),
    .done_o(md_done), .rem_o(md_rem)
  );

  // Effective sizes.
  logic [8:0] pn, cn;
  always_comb begin
    if (prgb_q == 6'd0) pn = 9'd1;
    else if ({3'd0, prgb_q} > 9'(PRG_BANKS_MAX)) pn = 9'(PRG_BANKS_MAX);
    else pn = {3'd0, prgb_q};
    cn = (chrb_q > 6'd32) ? 9'd32 : {3'd0, chrb_q};
  end

  logic [2:0] mk;
  assign mk = (mkind_q > MAP_EIGHT) ? MAP_FIXED : mkind_q;

  // Setup of one remainder job from the held transaction.
  logic [8:0]  c_num, c_div;
  logic [3:0]  c_sh;
  logic [13:0] c_low;
  logic        c_need, c_hit, c_wr;
  logic [2:0]  c_widx;
  logic [2:0]  region;
  logic [15:0] a;
  logic        hi;
  always_comb begin
    a = item_q.address;
    hi = a[14];
    c_num = '0; c_div = 9'd1; c_sh = 4'd14; c_low = '0;
    c_need = 1'b0; c_hit = 1'b0; c_wr = 1'b0; c_widx = bsel_q;
    region = a[12:10] ^ {modes_q[1], 2'b00};
    unique case (item_q.kind)
      KIND_CPU_READ: begin
        if (a[15]) begin
          c_hit = 1'b1; c_need = 1'b1;
          if (mk == MAP_EIGHT) begin
            c_div = {pn[7:0], 1'b0}; c_sh = 4'd13; c_low = {1'b0, a[12:0]};
            unique case (a[14:13])
              2'd0: c_num = modes_q[0] ? c_div - 9'd2 : {1'b0, bregs_q[6]};
              2'd1: c_num = {1'b0, bregs_q[7]};
              2'd2: c_num = modes_q[0] ? {1'b0, bregs_q[6]} : c_div - 9'd2;
              default: c_num = c_div - 9'd1;
            endcase
          end else begin
            c_div = pn; c_sh = 4'd14;
            c_low = a[13:0];
            if (mk == MAP_SERIAL) begin
              if (!ctrl_q[3]) c_num = {5'd0, sprg_q[3:1], hi};
              else if (ctrl_q[2]) c_num = hi ? pn - 9'd1 : {5'd0, sprg_q};
              else c_num = hi ? {5'd0, sprg_q} : 9'd0;
            end else if (mk == MAP_LOWSW) begin
              c_num = hi ? {4'd0, fixhi_q} : {1'b0, lowb_q};
            end else begin
              c_num = {8'd0, hi};
            end
          end
        end
      end
      KIND_PAT_READ: begin
        if (cn != 9'd0) begin
          c_hit = 1'b1; c_need = 1'b1; c_low = {1'b0, a[12:0]};
          if (mk == MAP_EIGHT) begin
            c_div = {cn[5:0], 3'd0}; c_sh = 4'd10;
            if (region < 3'd2) c_num = {1'b0, bregs_q[0][7:1], region[0]};
            else if (region < 3'd4) c_num = {1'b0, bregs_q[1][7:1], region[0]};
            else c_num = {1'b0, bregs_q[3'(region - 3'd2)]};
          end else if (mk == MAP_SERIAL && ctrl_q[4]) begin
            c_div = {cn[7:0], 1'b0}; c_sh = 4'd12;
            c_num = {4'd0, a[12] ? chrhi_q : chrlo_q};
          end else begin
            c_div = cn; c_sh = 4'd13;
            if (mk == MAP_SERIAL) c_num = {5'd0, chrlo_q[4:1]};
            else if (mk == MAP_PATSW) c_num = {1'b0, patb_q};
            else c_num = 9'd0;
          end
        end
      end
      KIND_CPU_WRITE: begin
        if (a[15] && mk == MAP_EIGHT && a[14:13] == 2'b00 && a[0]) begin
          if (bsel_q > 3'd5) begin
            c_need = 1'b1; c_wr = 1'b1; c_div = {pn[7:0], 1'b0};
            c_num = {1'b0, item_q.data};
          end else if (cn != 9'd0) begin
            c_need = 1'b1; c_wr = 1'b1; c_div = {cn[5:0], 3'd0};
            c_num = {1'b0, item_q.data};
          end
        end
      end
      default: ;
    endcase
  end

  // Offset assembly from the reduced bank number.
  logic [26:0] off;
  always_comb begin
    off = ({18'd0, md_rem} << shift_q);
    unique case (shift_q)
      4'd10: off = off | {17'd0, low_q[9:0]};
      4'd12: off = off | {15'd0, low_q[11:0]};
      4'd13: off = off | {14'd0, low_q[12:0]};
      default: off = off | {13'd0, low_q};
    endcase
  end

  assign md_start    = (st_q == ST_MOD);
  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);
  // Mirroring only changes while a transaction is being set up, so it is
  // already final when the result is presented.
  assign out_data_o  = {res_q.rom_hit, res_q.prg_offset, res_q.chr_offset, mirror_q};
  assign cfg_ready_o = 1'b1;

  logic [4:0] sh_new;
  assign sh_new = {item_q.data[0], shv_q[4:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      mkind_q <= MAP_FIXED; prgb_q <= 6'd1; chrb_q <= '0; fixhi_q <= '0;
      shv_q <= '0; shc_q <= '0; ctrl_q <= '0; chrlo_q <= '0; chrhi_q <= '0;
      sprg_q <= '0; bsel_q <= '0; modes_q <= '0; lowb_q <= '0; patb_q <= '0;
      mirror_q <= 1'b0;
      for (int i = 0; i < 8; i++) bregs_q[i] <= '0;
      wr_reg_q <= 1'b0;
      wr_idx_q <= '0; shift_q <= '0; low_q <= '0; res_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MAPPER_KIND: mkind_q <= cfg_data_i[2:0];
          CFG_PRG_BANKS:   prgb_q  <= cfg_data_i[5:0];
          CFG_CHR_BANKS:   chrb_q  <= cfg_data_i[5:0];
          default:         fixhi_q <= cfg_data_i[4:0];
        endcase
      end
      unique case (st_q)
        ST_IDLE: if (in_valid_i) st_q <= ST_CALC;
        ST_CALC: begin
          wr_reg_q <= c_wr; wr_idx_q <= c_widx;
          shift_q <= c_sh; low_q <= c_low;
          res_q.rom_hit <= c_hit; res_q.prg_offset <= '0; res_q.chr_offset <= '0;
          if (item_q.kind == KIND_CPU_WRITE && item_q.address[15]) begin
            if (mk == MAP_SERIAL) begin
              if (item_q.data[7]) begin
                shv_q <= '0; shc_q <= '0;
              end else if (shc_q == 3'd4) begin
                shv_q <= '0; shc_q <= '0;
                unique case (item_q.address[14:13])
                  2'd0: begin
                    ctrl_q <= sh_new;
                    if (sh_new[1]) mirror_q <= sh_new[0];
                  end
                  2'd1: chrlo_q <= sh_new;
                  2'd2: chrhi_q <= sh_new;
                  default: sprg_q <= sh_new[3:0];
                endcase
              end else begin
                shv_q <= sh_new; shc_q <= shc_q + 3'd1;
              end
            end else if (mk == MAP_LOWSW) lowb_q <= item_q.data;
            else if (mk == MAP_PATSW) patb_q <= item_q.data;
            else if (mk == MAP_EIGHT) begin
              if (item_q.address[14:13] == 2'b00 && !item_q.address[0]) begin
                modes_q <= {item_q.data[7], item_q.data[6]};
                bsel_q <= item_q.data[2:0];
              end else if (item_q.address[14:13] == 2'b01 && !item_q.address[0]) begin
                mirror_q <= item_q.data[0];
              end
            end
          end
          st_q <= c_need ? ST_MOD : ST_OUT;
        end
        ST_MOD: st_q <= ST_WAIT;
        ST_WAIT: if (md_done) begin
          if (wr_reg_q) bregs_q[wr_idx_q] <= md_rem[7:0];
          else if (item_q.kind == KIND_CPU_READ) res_q.prg_offset <= off[18:0];
          else res_q.chr_offset <= off[17:0];
          st_q <= ST_OUT;
        end
        ST_OUT: if (!out_stall_i) st_q <= ST_IDLE;
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE) item_q <= in_data_i;
    if (st_q == ST_CALC) begin
      num_q <= c_num;
      div_q <= c_div;
    end
  end
endmodule
